/* sv/ascte_pkg.sv */
`default_nettype none
package ascte_pkg;

    localparam int MaxParams = 16;
    localparam int PcntW     = $clog2(MaxParams + 1);
    localparam int PidxW     = $clog2(MaxParams);

    localparam logic [7:0] ChEsc  = 8'h1B;
    localparam logic [7:0] ChLf   = 8'h0A;
    localparam logic [7:0] ChLbr  = 8'h5B;
    localparam logic [7:0] ChSemi = 8'h3B;
    localparam logic [7:0] ChM    = 8'h6D;
    localparam logic [7:0] ChD0   = 8'h30;
    localparam logic [7:0] ChD9   = 8'h39;

    localparam logic [1:0] ActParse = 2'd0;
    localparam logic [1:0] ActGlyph = 2'd1;
    localparam logic [1:0] ActLine  = 2'd2;

    localparam logic [0:0] RegCols = 1'b0;
    localparam logic [0:0] RegRows = 1'b1;

    typedef enum logic [1:0] {MODE_NORMAL, MODE_ESC, MODE_CSI} t_mode;
    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SGR, ST_DONE} t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic sgr_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic go_sgr;
        logic sgr_done;
        logic out_free;
    } t_status;

    // {red, green, blue}
    function automatic logic [23:0] base_rgb(input logic [3:0] i);
        logic [23:0] v;
        case (i)
            4'd0:    v = {8'd0, 8'd0, 8'd0};
            4'd1:    v = {8'd205, 8'd0, 8'd0};
            4'd2:    v = {8'd0, 8'd205, 8'd0};
            4'd3:    v = {8'd205, 8'd205, 8'd0};
            4'd4:    v = {8'd0, 8'd0, 8'd238};
            4'd5:    v = {8'd205, 8'd0, 8'd205};
            4'd6:    v = {8'd0, 8'd205, 8'd205};
            4'd7:    v = {8'd229, 8'd229, 8'd229};
            4'd8:    v = {8'd127, 8'd127, 8'd127};
            4'd9:    v = {8'd255, 8'd0, 8'd0};
            4'd10:   v = {8'd0, 8'd255, 8'd0};
            4'd11:   v = {8'd255, 8'd255, 8'd0};
            4'd12:   v = {8'd92, 8'd92, 8'd255};
            4'd13:   v = {8'd255, 8'd0, 8'd255};
            4'd14:   v = {8'd0, 8'd255, 8'd255};
            default: v = {8'd255, 8'd255, 8'd255};
        endcase
        return v;
    endfunction

    function automatic logic [7:0] cube_step(input logic [2:0] i);
        logic [7:0] v;
        case (i)
            3'd0:    v = 8'd0;
            3'd1:    v = 8'd95;
            3'd2:    v = 8'd135;
            3'd3:    v = 8'd175;
            3'd4:    v = 8'd215;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

    function automatic logic [23:0] map_256(input logic [7:0] code);
        logic [7:0]  k;
        logic [2:0]  q36;
        logic [7:0]  r36;
        logic [2:0]  q6;
        logic [7:0]  r6;
        logic [7:0]  g;
        logic [23:0] v;
        k = code - 8'd16;
        // cube index split into base-6 digits by compare and subtract
        if (k >= 8'd180)      q36 = 3'd5;
        else if (k >= 8'd144) q36 = 3'd4;
        else if (k >= 8'd108) q36 = 3'd3;
        else if (k >= 8'd72)  q36 = 3'd2;
        else if (k >= 8'd36)  q36 = 3'd1;
        else                  q36 = 3'd0;
        r36 = k - {5'd0, q36} * 8'd36;
        if (r36 >= 8'd30)      q6 = 3'd5;
        else if (r36 >= 8'd24) q6 = 3'd4;
        else if (r36 >= 8'd18) q6 = 3'd3;
        else if (r36 >= 8'd12) q6 = 3'd2;
        else if (r36 >= 8'd6)  q6 = 3'd1;
        else                   q6 = 3'd0;
        r6 = r36 - {5'd0, q6} * 8'd6;
        g = 8'd8 + (code - 8'd232) * 8'd10;
        if (code < 8'd16) begin
            v = base_rgb(code[3:0]);
        end else if (code >= 8'd232) begin
            v = {g, g, g};
        end else begin
            v = {cube_step(q36), cube_step(q6), cube_step(r6[2:0])};
        end
        return v;
    endfunction

endpackage
`default_nettype wire

/* sv/ascte_ctrl.sv */
`default_nettype none
module ascte_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire ascte_pkg::t_status i_status,
    output ascte_pkg::t_cmd        o_cmd
);
    import ascte_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = i_status.go_sgr ? ST_SGR : ST_DONE;
            end
            ST_SGR: begin
                if (i_status.sgr_done) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.sgr_step = 1'b1;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* sv/ascte_dp.sv */
`default_nettype none
module ascte_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ascte_pkg::t_cmd   i_cmd,
    output ascte_pkg::t_status     o_status,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_cfg_we,
    input  wire logic [0:0]        i_cfg_index,
    input  wire logic [9:0]        i_cfg_data,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [1:0]             o_action,
    output logic [79:0]            o_data
);
    import ascte_pkg::*;

    logic [9:0]  r_cols, r_rows;
    logic [7:0]  r_byte;
    t_mode       r_mode;
    logic [15:0] r_store [MaxParams];
    logic [PcntW-1:0] r_cnt;
    logic [15:0] r_cur;
    logic        r_has;
    logic [23:0] r_fore, r_back;
    logic [8:0]  r_col, r_row;
    logic [1:0]  r_res_act;
    logic [7:0]  r_res_glyph;
    logic [8:0]  r_res_col, r_res_row;
    logic        r_res_scroll;
    logic        r_ovalid;
    logic [1:0]  r_oact;
    logic [79:0] r_odata;

    logic [9:0]  cols_c, rows_c;
    logic [9:0]  col_inc, row_inc;
    logic        row_wrap;
    logic [8:0]  row_adv;
    logic        is_digit;
    logic [19:0] cur_mul;
    logic [15:0] cur_next;
    logic [15:0] push_val;
    logic [PcntW-1:0] cnt_push;
    logic        take3;

    assign cols_c = (r_cols == 10'd0) ? 10'd1 : ((r_cols > 10'd512) ? 10'd512 : r_cols);
    assign rows_c = (r_rows == 10'd0) ? 10'd1 : ((r_rows > 10'd512) ? 10'd512 : r_rows);
    assign col_inc  = {1'b0, r_col} + 10'd1;
    assign row_inc  = {1'b0, r_row} + 10'd1;
    assign row_wrap = row_inc >= rows_c;
    assign row_adv  = row_wrap ? 9'(rows_c - 10'd1) : row_inc[8:0];

    assign is_digit = (r_byte >= ChD0) && (r_byte <= ChD9);
    assign cur_mul  = {4'd0, r_cur} * 20'd10 + {12'd0, r_byte[3:0]};
    assign cur_next = (cur_mul > 20'd65535) ? 16'hFFFF : cur_mul[15:0];
    assign push_val = r_has ? r_cur : 16'd0;
    assign cnt_push = (r_cnt < PcntW'(MaxParams)) ? r_cnt + PcntW'(1) : r_cnt;

    // extended color needs two more stored params, the first one being 5
    assign take3 = (r_cnt > PcntW'(2)) && (r_store[1] == 16'd5) &&
                   ((r_store[0] == 16'd38) || (r_store[0] == 16'd48));

    assign o_status.go_sgr   = (r_mode == MODE_CSI) && (r_byte == ChM);
    assign o_status.sgr_done = (r_cnt == '0);
    assign o_status.out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 10'd80;
            r_rows <= 10'd25;
        end else if (i_cfg_we) begin
            if (i_cfg_index == RegCols) begin
                r_cols <= i_cfg_data;
            end else begin
                r_rows <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_byte <= i_byte;
        end
        if (i_cmd.exec && r_mode == MODE_CSI && !is_digit &&
            r_cnt < PcntW'(MaxParams)) begin
            r_store[r_cnt[PidxW-1:0]] <= push_val;
        end
        if (i_cmd.sgr_step) begin
            for (int j = 0; j < MaxParams; j++) begin
                if (take3) begin
                    if (j + 3 < MaxParams) r_store[j] <= r_store[j + 3];
                end else begin
                    if (j + 1 < MaxParams) r_store[j] <= r_store[j + 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_cnt    <= '0;
            r_cur    <= 16'd0;
            r_has    <= 1'b0;
            r_fore   <= 24'hFFFFFF;
            r_back   <= 24'h000000;
            r_col    <= 9'd0;
            r_row    <= 9'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_res_act    <= ActParse;
                r_res_glyph  <= 8'd0;
                r_res_col    <= r_col;
                r_res_row    <= r_row;
                r_res_scroll <= 1'b0;
                if (r_mode == MODE_NORMAL && r_byte != ChEsc) begin
                    if (r_byte == ChLf) begin
                        r_res_act    <= ActLine;
                        r_col        <= 9'd0;
                        r_row        <= row_adv;
                        r_res_col    <= 9'd0;
                        r_res_row    <= row_adv;
                        r_res_scroll <= row_wrap;
                    end else begin
                        r_res_act   <= ActGlyph;
                        r_res_glyph <= r_byte;
                        if (col_inc >= cols_c) begin
                            r_col        <= 9'd0;
                            r_row        <= row_adv;
                            r_res_scroll <= row_wrap;
                        end else begin
                            r_col <= col_inc[8:0];
                        end
                    end
                end else if (r_mode == MODE_NORMAL) begin
                    r_mode <= MODE_ESC;
                end else if (r_mode == MODE_ESC) begin
                    if (r_byte == ChLbr) begin
                        r_mode <= MODE_CSI;
                        r_cnt  <= '0;
                        r_cur  <= 16'd0;
                        r_has  <= 1'b0;
                    end else begin
                        r_mode <= MODE_NORMAL;
                    end
                end else if (is_digit) begin
                    r_cur <= cur_next;
                    r_has <= 1'b1;
                end else begin
                    r_cnt <= cnt_push;
                    r_cur <= 16'd0;
                    r_has <= 1'b0;
                    if (r_byte != ChSemi) begin
                        r_mode <= MODE_NORMAL;
                        if (r_byte != ChM) begin
                            r_cnt <= '0;
                        end
                    end
                end
            end
            if (i_cmd.sgr_step) begin
                r_cnt <= take3 ? r_cnt - PcntW'(3) : r_cnt - PcntW'(1);
                if (take3) begin
                    if (r_store[0] == 16'd38) r_fore <= map_256(r_store[2][7:0]);
                    else                      r_back <= map_256(r_store[2][7:0]);
                end else if (r_store[0] == 16'd0) begin
                    r_fore <= {8'd200, 8'd200, 8'd200};
                    r_back <= 24'h000000;
                end else if (r_store[0] >= 16'd30 && r_store[0] <= 16'd37) begin
                    r_fore <= base_rgb({1'b0, 3'(r_store[0] - 16'd30)});
                end else if (r_store[0] == 16'd39) begin
                    r_fore <= 24'hFFFFFF;
                end else if (r_store[0] >= 16'd40 && r_store[0] <= 16'd47) begin
                    r_back <= base_rgb({1'b0, 3'(r_store[0] - 16'd40)});
                end else if (r_store[0] == 16'd49) begin
                    r_back <= 24'h000000;
                end else if (r_store[0] >= 16'd90 && r_store[0] <= 16'd97) begin
                    r_fore <= base_rgb({1'b1, 3'(r_store[0] - 16'd90)});
                end else if (r_store[0] >= 16'd100 && r_store[0] <= 16'd107) begin
                    r_back <= base_rgb({1'b1, 3'(r_store[0] - 16'd100)});
                end
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_oact  <= r_res_act;
            r_odata <= {5'd0, r_res_scroll, r_back[7:0], r_back[15:8], r_back[23:16],
                        r_fore[7:0], r_fore[15:8], r_fore[23:16],
                        r_res_row, r_res_col, r_res_glyph};
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_action    = r_oact;
    assign o_data      = r_odata;
endmodule
`default_nettype wire

/* sv/ansi_sgr_terminal_cursor_engine.sv */
// Each byte passes through capture, execute and output load; the SGR final
// byte 'm' adds a walk over the stored parameters (up to 16 steps),
// fewer steps for 38/48;5;n.
// Bytes are taken one at a time, after the previous one is loaded for output.
// A finished word waits in the output register while the next byte is taken.
// Reset (i_rst_n low, synchronous): normal text mode, cursor 0,0, white on black,
// 80 columns by 25 rows, output empty.
`default_nettype none
module ansi_sgr_terminal_cursor_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // text_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // glyph[7:0] cell_column[16:8] cell_row[25:17] fore_red[33:26] fore_green[41:34]
    // fore_blue[49:42] back_red[57:50] back_green[65:58] back_blue[73:66] scroll_up[74]
    output logic [79:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,   // action
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data
);
    import ascte_pkg::*;

    t_cmd    cmd;
    t_status status;

    ascte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ascte_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_byte      (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_action    (m_axis_tuser),
        .o_data      (m_axis_tdata)
    );
endmodule
`default_nettype wire

/* sv/ascte_checker.sv */
`default_nettype none
module ascte_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [79:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);
    import ascte_pkg::*;

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled word changed");

    a_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser == ActParse || m_axis_tuser == ActGlyph ||
                          m_axis_tuser == ActLine)
        else $error("bad action code");

    a_parse_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ActParse |->
            m_axis_tdata[7:0] == 8'd0 && !m_axis_tdata[74])
        else $error("parser word carries glyph or scroll");
endmodule

bind ansi_sgr_terminal_cursor_engine ascte_checker u_ascte_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

/* bench/ansi_sgr_terminal_cursor_engine_tb.sv */
`default_nettype none
module ansi_sgr_terminal_cursor_engine_tb;
    import ascte_pkg::*;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] glyph;
        logic [8:0] col;
        logic [8:0] row;
        logic [23:0] fore;
        logic [23:0] back;
        logic       scroll;
    } t_cell_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [9:0]  i_cfg_data;

    ansi_sgr_terminal_cursor_engine dut (.*);

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow terminal state
    logic [9:0]  term_cols;
    logic [9:0]  term_rows;
    t_mode       pmode;
    logic [15:0] pstore [MaxParams];
    int          pcount;
    logic [15:0] pcur;
    logic        pdigit;
    logic [23:0] fore_rgb;
    logic [23:0] back_rgb;
    int          cur_col;
    int          cur_row;

    t_cell_out   expected_cells[$];
    int          fail_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;

    function automatic logic [23:0] palette16(input int i);
        case (i)
            0:  return {8'd0, 8'd0, 8'd0};
            1:  return {8'd205, 8'd0, 8'd0};
            2:  return {8'd0, 8'd205, 8'd0};
            3:  return {8'd205, 8'd205, 8'd0};
            4:  return {8'd0, 8'd0, 8'd238};
            5:  return {8'd205, 8'd0, 8'd205};
            6:  return {8'd0, 8'd205, 8'd205};
            7:  return {8'd229, 8'd229, 8'd229};
            8:  return {8'd127, 8'd127, 8'd127};
            9:  return {8'd255, 8'd0, 8'd0};
            10: return {8'd0, 8'd255, 8'd0};
            11: return {8'd255, 8'd255, 8'd0};
            12: return {8'd92, 8'd92, 8'd255};
            13: return {8'd255, 8'd0, 8'd255};
            14: return {8'd0, 8'd255, 8'd255};
            default: return {8'd255, 8'd255, 8'd255};
        endcase
    endfunction

    function automatic logic [7:0] cube_level(input int i);
        int lv[6] = '{0, 95, 135, 175, 215, 255};
        return 8'(lv[i]);
    endfunction

    function automatic logic [23:0] xterm_color(input logic [15:0] p);
        int c;
        int k;
        logic [7:0] g;
        c = p[7:0];
        k = c - 16;
        g = 8'(8 + (c - 232) * 10);
        if (c < 16) return palette16(c);
        if (c >= 232) return {g, g, g};
        return {cube_level(k / 36), cube_level((k / 6) % 6), cube_level(k % 6)};
    endfunction

    function automatic int clamp_dim(input logic [9:0] v);
        if (v == 0) return 1;
        return (v > 512) ? 512 : int'(v);
    endfunction

    function automatic logic next_row();
        cur_row++;
        if (cur_row >= clamp_dim(term_rows)) begin
            cur_row = clamp_dim(term_rows) - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void close_param();
        if (pcount < MaxParams) begin
            pstore[pcount] = pdigit ? pcur : 16'd0;
            pcount++;
        end
        pcur = 0;
        pdigit = 1'b0;
    endfunction

    function automatic void run_sgr();
        int p;
        if (pcount == 0) begin
            fore_rgb = {3{8'd200}};
            back_rgb = '0;
            return;
        end
        for (int i = 0; i < pcount; i++) begin
            p = pstore[i];
            if (p == 0) begin
                fore_rgb = {3{8'd200}};
                back_rgb = '0;
            end else if (p >= 30 && p <= 37) begin
                fore_rgb = palette16(p - 30);
            end else if (p == 38 && i + 2 < pcount && pstore[i+1] == 5) begin
                fore_rgb = xterm_color(pstore[i+2]);
                i += 2;
            end else if (p == 39) begin
                fore_rgb = '1;
            end else if (p >= 40 && p <= 47) begin
                back_rgb = palette16(p - 40);
            end else if (p == 48 && i + 2 < pcount && pstore[i+1] == 5) begin
                back_rgb = xterm_color(pstore[i+2]);
                i += 2;
            end else if (p == 49) begin
                back_rgb = '0;
            end else if (p >= 90 && p <= 97) begin
                fore_rgb = palette16(p - 82);
            end else if (p >= 100 && p <= 107) begin
                back_rgb = palette16(p - 92);
            end
        end
    endfunction

    function automatic t_cell_out predict_cell(input logic [7:0] c);
        t_cell_out r;
        int v;
        r = '0;
        if (pmode == MODE_NORMAL && c != ChEsc) begin
            if (c == ChLf) begin
                r.action = ActLine;
                cur_col = 0;
                r.scroll = next_row();
                r.col = 9'(cur_col);
                r.row = 9'(cur_row);
            end else begin
                r.action = ActGlyph;
                r.glyph = c;
                r.col = 9'(cur_col);
                r.row = 9'(cur_row);
                cur_col++;
                if (cur_col >= clamp_dim(term_cols)) begin
                    cur_col = 0;
                    r.scroll = next_row();
                end
            end
        end else begin
            r.action = ActParse;
            if (pmode == MODE_NORMAL) begin
                pmode = MODE_ESC;
            end else if (pmode == MODE_ESC) begin
                if (c == ChLbr) begin
                    pmode = MODE_CSI;
                    pcount = 0;
                    pcur = 0;
                    pdigit = 1'b0;
                end else begin
                    pmode = MODE_NORMAL;
                end
            end else if (c >= ChD0 && c <= ChD9) begin
                v = int'(pcur) * 10 + int'(c - ChD0);
                pcur = (v > 65535) ? 16'hFFFF : 16'(v);
                pdigit = 1'b1;
            end else if (c == ChSemi) begin
                close_param();
            end else begin
                close_param();
                if (c == ChM) run_sgr();
                pmode = MODE_NORMAL;
            end
            r.col = 9'(cur_col);
            r.row = 9'(cur_row);
        end
        r.fore = fore_rgb;
        r.back = back_rgb;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_cells.push_back(predict_cell(b));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_cells.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [9:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == RegCols) term_cols = val;
        else term_rows = val;
    endtask

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_cell_out got;
        t_cell_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.action = m_axis_tuser;
            got.glyph  = m_axis_tdata[7:0];
            got.col    = m_axis_tdata[16:8];
            got.row    = m_axis_tdata[25:17];
            got.fore   = m_axis_tdata[49:26];
            got.back   = m_axis_tdata[73:50];
            got.scroll = m_axis_tdata[74];
            // tdata fore/back are packed red lowest; reorder to {r,g,b}
            got.fore = {m_axis_tdata[33:26], m_axis_tdata[41:34], m_axis_tdata[49:42]};
            got.back = {m_axis_tdata[57:50], m_axis_tdata[65:58], m_axis_tdata[73:66]};
            if (expected_cells.size() == 0) begin
                $display("%0t unexpected word act=%0d data=%h", $time, m_axis_tuser,
                         m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_cells.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch expected %h actual %h", $time, want, got);
                    fail_count++;
                end
            end
        end
    end

    function automatic string rand_number();
        int n;
        case ($urandom_range(5))
            0: n = $urandom_range(9);
            1: n = 30 + $urandom_range(17);
            2: n = 90 + $urandom_range(17);
            3: n = $urandom_range(255);
            4: n = $urandom_range(99999);
            default: n = $urandom_range(49);
        endcase
        return $sformatf("%0d", n);
    endfunction

    task automatic test_directed();
        send_text("Hi");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("\n");
        send_text({8'h1B, "[31;42mA"});
        send_text({8'h1B, "[38;5;196;48;5;244mB"});
        send_text({8'h1B, "[99999;;1mC"});
        send_text({8'h1B, "[mD"});
        send_text({8'h1B, "xE"});
        send_text({8'h1B, "[38;5m", 8'h1B, "[91;103;39;49;0m"});
        send_text({8'h1B, "[1", 8'h1B, "F"});
        send_text({8'h1B, "[1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;31;0H"});
        send_text({8'h1B, "[48;5;21;38;5;500m"});
    endtask

    task automatic test_sizes();
        write_reg(RegCols, 10'd1);
        write_reg(RegRows, 10'd1);
        send_text("ab\nc");
        write_reg(RegCols, 10'd0);
        write_reg(RegRows, 10'd0);
        send_text("de\n");
        write_reg(RegCols, 10'd1023);
        write_reg(RegRows, 10'd600);
        for (int i = 0; i < 520; i++) send_byte(8'h41);
        send_text("\n");
        write_reg(RegCols, 10'd3);
        write_reg(RegRows, 10'd2);
        send_text("xyz\n\nw");
    endtask

    task automatic test_random(input int count);
        int n;
        string s;
        n = 0;
        while (n < count) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    s = {8'h1B, "["};
                    repeat ($urandom_range(5)) s = {s, rand_number(), ";"};
                    if ($urandom_range(2) == 0) s = {s, ($urandom_range(1) ? "38" : "48"),
                                                 ";5;", rand_number()};
                    else s = {s, rand_number()};
                    s = {s, ($urandom_range(7) == 0) ? "J" : "m"};
                    send_text(s);
                    n += s.len();
                end
                4: begin
                    send_byte(8'h0A);
                    n++;
                end
                5: begin
                    send_byte(8'($urandom_range(255)));
                    n++;
                end
                default: begin
                    repeat ($urandom_range(1, 6)) begin
                        send_byte(8'($urandom_range(32, 126)));
                        n++;
                    end
                end
            endcase
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        repeat (24) send_byte(8'($urandom_range(32, 126)));
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        fail_count = 0;
        hold_cycles = 0;
        send_idle_pct = 22;
        recv_idle_pct = 83;
        term_cols = 10'd80;
        term_rows = 10'd25;
        pmode = MODE_NORMAL;
        pcount = 0;
        pcur = 0;
        pdigit = 1'b0;
        fore_rgb = '1;
        back_rgb = '0;
        cur_col = 0;
        cur_row = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(15);
        send_idle_pct = 83;
        recv_idle_pct = 22;
        test_sizes();
        write_reg(RegCols, 10'd7);
        write_reg(RegRows, 10'd4);
        test_random(15);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(RegCols, 10'd512);
        write_reg(RegRows, 10'd512);
        test_random(15);
        write_reg(RegCols, 10'd80);
        write_reg(RegRows, 10'd25);
        test_random(15);
        drain();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
